@@ hw/rtl/dpdl_pkg.sv @@
`timescale 1ns / 1ps

package dpdl_pkg;

   // most results one item may give
   localparam int unsigned MAX_RESULTS = 10;
   localparam int unsigned COUNT_W     = $clog2(MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_LOAD,
      ST_DIV,
      ST_CHECK,
      ST_PUSH_D,
      ST_PUSH_R,
      ST_FLUSH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // take a new item
      logic div_load;   // start remainder of r by d
      logic div_step;   // one quotient bit
      logic take_q;     // r <= quotient
      logic set_found;  // d divides, inner loop active
      logic advance;    // next trial divisor, leave inner loop
      logic push_d;     // pending out, d becomes pending
      logic push_r;     // pending out, cofactor becomes pending
      logic flush;      // pending out as the last item
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_zero;
      logic div_done;
      logic d_gt_q;
      logic rem_zero;
      logic found;
      logic r_gt_one;
      logic count_full;
      logic out_free;
   } status_type;

endpackage

@@ hw/rtl/dpdl_if.sv @@
`timescale 1ns / 1ps

interface dpdl_req_if #(
   parameter int unsigned NUMBER_BITS = 31
);
   logic                   valid;
   logic                   ready;
   logic [NUMBER_BITS-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface dpdl_rsp_if #(
   parameter int unsigned NUMBER_BITS = 31
);
   logic                   valid;
   logic                   ready;
   logic [NUMBER_BITS-1:0] prime_divisor;
   logic                   last;
   logic                   empty_res;

   modport source (output valid, output prime_divisor, output last, output empty_res,
                   input ready);
   modport sink   (input valid, input prime_divisor, input last, input empty_res,
                   output ready);
endinterface

@@ hw/rtl/distinct_prime_divisor_lister.sv @@
// sequencing: each divide loads, takes NUMBER_BITS quotient steps, sees done and is checked;
//    one more divide each time a factor is divided out, a push state per result item; trial
//    divisors run 2, 3, 5, ... up to the square root
// one item at a time, taken in idle; the bit-serial divider and result stalls set each run
// a zero item's single result passes the flush state into the output register
// reset: synchronous, active high; returns to idle with no result pending
`timescale 1ns / 1ps

module distinct_prime_divisor_lister #(
   parameter int unsigned NUMBER_BITS = 31
) (
   input  logic       clock,
   input  logic       reset,
   dpdl_req_if.sink   req,
   dpdl_rsp_if.source rsp
);
   // command and status between sequencer and datapath
   dpdl_pkg::cmd_type    cmd;
   dpdl_pkg::status_type status;

   // sequencer: trial loop, inner divide-out loop, result hand-off
   dpdl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: cofactor, trial divisor, shared divider, pending item and output register
   dpdl_datapath #(
      .NUMBER_BITS (NUMBER_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_number        (req.number),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp.valid),
      .rsp_ready         (rsp.ready),
      .rsp_prime_divisor (rsp.prime_divisor),
      .rsp_last          (rsp.last),
      .rsp_empty_res     (rsp.empty_res)
   );

endmodule

@@ hw/rtl/dpdl_datapath.sv @@
`timescale 1ns / 1ps

module dpdl_datapath #(
   parameter int unsigned NUMBER_BITS = 31
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [NUMBER_BITS-1:0]  req_number,
   input  dpdl_pkg::cmd_type       cmd,
   output dpdl_pkg::status_type    status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [NUMBER_BITS-1:0]  rsp_prime_divisor,
   output logic                    rsp_last,
   output logic                    rsp_empty_res
);
   localparam int unsigned W  = NUMBER_BITS;
   localparam int unsigned CW = $clog2(W + 1);

   logic [W-1:0]                 r_ff, r_in;
   logic [W-1:0]                 d_ff, d_in;
   logic [W-1:0]                 rem_ff, rem_in;
   logic [W-1:0]                 quo_ff, quo_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         found_ff, found_in;
   logic [W-1:0]                 pend_ff, pend_in;
   logic                         pend_empty_ff, pend_empty_in;
   logic [dpdl_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         out_valid_ff, out_valid_in;
   logic [W-1:0]                 out_val_ff, out_val_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_empty_ff, out_empty_in;

   logic [W:0]   shifted;
   logic [W:0]   diff;
   logic         fits;
   logic         out_free;
   logic         emit;

   // restoring divider, one quotient bit per step
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign diff    = shifted - {1'b0, d_ff};
   assign fits    = (shifted >= {1'b0, d_ff});

   assign out_free = !out_valid_ff || rsp_ready;
   assign emit     = cmd.push_d || cmd.push_r || cmd.flush;

   always_comb begin
      r_in          = r_ff;
      d_in          = d_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      pend_in       = pend_ff;
      pend_empty_in = pend_empty_ff;
      count_in      = count_ff;
      out_val_in    = out_val_ff;
      out_last_in   = out_last_ff;
      out_empty_in  = out_empty_ff;
      out_valid_in  = rsp_ready ? 1'b0 : out_valid_ff;

      if (cmd.load) begin
         r_in          = req_number;
         d_in          = W'(2);
         found_in      = 1'b0;
         pend_in       = (req_number == '0) ? '0 : W'(1);
         pend_empty_in = (req_number == '0);
         count_in      = dpdl_pkg::COUNT_W'(1);
      end
      if (cmd.div_load) begin
         rem_in = '0;
         quo_in = r_ff;
         cnt_in = CW'(W);
      end
      if (cmd.div_step) begin
         rem_in = fits ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
      end
      if (cmd.take_q || cmd.push_d) begin
         r_in = quo_ff;
      end
      if (cmd.set_found || cmd.push_d) begin
         found_in = 1'b1;
      end
      if (cmd.advance) begin
         d_in     = (d_ff == W'(2)) ? W'(3) : d_ff + W'(2);
         found_in = 1'b0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_val_in   = pend_ff;
         out_last_in  = cmd.flush;
         out_empty_in = cmd.flush && pend_empty_ff;
      end
      if (cmd.push_d) begin
         pend_in  = d_ff;
         count_in = count_ff + dpdl_pkg::COUNT_W'(1);
      end
      if (cmd.push_r) begin
         pend_in  = r_ff;
         count_in = count_ff + dpdl_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff          <= r_in;
      d_ff          <= d_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      pend_ff       <= pend_in;
      pend_empty_ff <= pend_empty_in;
      out_val_ff    <= out_val_in;
      out_last_ff   <= out_last_in;
      out_empty_ff  <= out_empty_in;
   end

   always_comb begin
      status.req_zero   = (req_number == '0);
      status.div_done   = (cnt_ff == '0);
      status.d_gt_q     = (d_ff > quo_ff);
      status.rem_zero   = (rem_ff == '0);
      status.found      = found_ff;
      status.r_gt_one   = (r_ff > W'(1));
      status.count_full = (count_ff >= dpdl_pkg::COUNT_W'(dpdl_pkg::MAX_RESULTS));
      status.out_free   = out_free;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_prime_divisor = out_val_ff;
   assign rsp_last          = out_last_ff;
   assign rsp_empty_res     = out_empty_ff;

   // never overwrite an item that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result overwritten");

   // divider counter stays within the word width
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(W))
      else $error("divider count out of range");

   // result count never passes the limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dpdl_pkg::COUNT_W'(dpdl_pkg::MAX_RESULTS))
      else $error("too many results");

endmodule

@@ hw/rtl/dpdl_ctrl.sv @@
`timescale 1ns / 1ps

module dpdl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dpdl_pkg::status_type status,
   output dpdl_pkg::cmd_type    cmd
);
   dpdl_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dpdl_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.req_zero ? dpdl_pkg::ST_FLUSH : dpdl_pkg::ST_DIV_LOAD;
            end
         end
         dpdl_pkg::ST_DIV_LOAD: state_in = dpdl_pkg::ST_DIV;
         dpdl_pkg::ST_DIV: begin
            if (status.div_done) state_in = dpdl_pkg::ST_CHECK;
         end
         dpdl_pkg::ST_CHECK: begin
            if (status.found) begin
               state_in = dpdl_pkg::ST_DIV_LOAD;
            end else if (status.d_gt_q) begin
               state_in = status.r_gt_one ? dpdl_pkg::ST_PUSH_R : dpdl_pkg::ST_FLUSH;
            end else if (status.rem_zero && !status.count_full) begin
               state_in = dpdl_pkg::ST_PUSH_D;
            end else begin
               state_in = dpdl_pkg::ST_DIV_LOAD;
            end
         end
         dpdl_pkg::ST_PUSH_D: begin
            if (status.out_free) state_in = dpdl_pkg::ST_DIV_LOAD;
         end
         dpdl_pkg::ST_PUSH_R: begin
            if (status.count_full || status.out_free) state_in = dpdl_pkg::ST_FLUSH;
         end
         dpdl_pkg::ST_FLUSH: begin
            if (status.out_free) state_in = dpdl_pkg::ST_IDLE;
         end
         default: state_in = dpdl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         dpdl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         dpdl_pkg::ST_DIV_LOAD: cmd.div_load = 1'b1;
         dpdl_pkg::ST_DIV:      cmd.div_step = !status.div_done;
         dpdl_pkg::ST_CHECK: begin
            if (status.found) begin
               cmd.take_q  = status.rem_zero;
               cmd.advance = !status.rem_zero;
            end else if (!status.d_gt_q) begin
               if (!status.rem_zero) begin
                  cmd.advance = 1'b1;
               end else if (status.count_full) begin
                  // divisor dropped, still divide it out
                  cmd.take_q    = 1'b1;
                  cmd.set_found = 1'b1;
               end
            end
         end
         dpdl_pkg::ST_PUSH_D: cmd.push_d = status.out_free;
         dpdl_pkg::ST_PUSH_R: cmd.push_r = status.out_free && !status.count_full;
         dpdl_pkg::ST_FLUSH:  cmd.flush  = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dpdl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // at most one result moves per cycle
   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.push_d, cmd.push_r, cmd.flush}))
      else $error("several results at once");

   // the last item of a run ends it
   a_flush_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> state_ff == dpdl_pkg::ST_IDLE)
      else $error("run did not end after last item");

   // a divide keeps going until its count runs out
   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dpdl_pkg::ST_DIV && !status.div_done) |=> state_ff == dpdl_pkg::ST_DIV)
      else $error("divide cut short");

endmodule
